[hdl/bte_pkg.sv]
package bte_pkg;

    // field widths
    localparam int TEMP_W     = 17;
    localparam int GAIN_W     = 16;
    localparam int HEIGHT_W   = 14;
    localparam int HEAT_W     = 20;
    localparam int HOT_W      = 20;
    localparam int COLD_W     = 23;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // default number of fraction bits in the flow quotients
    localparam int FRAC_BITS_DEF = 16;

    // divider operand widths: magnitude of numerator, scaled divisor
    localparam int NUM_W = 63;
    localparam int DEN_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_GAIN   = 2'd1
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_HOT_NEG  = 2'd2
    } status_t;

    // per-sample decisions that ride along with the divider
    typedef struct packed {
        logic              dpos;      // positive demand
        logic              dneg;      // negative demand
        logic              qge;       // heater demand reaches its cap
        logic [HEAT_W-1:0] heat_lo;   // heater power when below the cap
        logic              da_zero;   // hot water at the hot supply temperature
        logic              da_neg;    // hot inflow quotient is negative
        logic              di_zero;   // inlet equals water temperature
        logic              neg_c;     // cold inflow quotient is negative
    } ctl_t;

endpackage

[hdl/boiler_temperature_actuator_split.sv]
// channel    | direction | handshake                  | payload
// -----------+-----------+----------------------------+------------------------------------
// sample     | in        | start, busy                | water_temp, inlet_temp,
//            |           |                            | ambient_temp, water_height
// result     | out       | done (one-cycle strobe)    | heater_power, hot_inflow,
//            |           |                            | cold_inflow, status
// config     | in        | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// one sample per cycle; each sample passes through stages 1 to 4, the
// one-bit-per-stage flow dividers and the output register to its result
// busy and cfg_ready stay low and high: the pipeline never stalls
// reset clears valid bits and loads the set point and gain defaults
// the receiver cannot stall; results leave in sample order
module boiler_temperature_actuator_split
    import bte_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [TEMP_W-1:0]     water_temp,
    input  logic [TEMP_W-1:0]     inlet_temp,
    input  logic [TEMP_W-1:0]     ambient_temp,
    input  logic [HEIGHT_W-1:0]   water_height,
    output logic                  done,
    output logic [HEAT_W-1:0]     heater_power,
    output logic [HOT_W-1:0]      hot_inflow,
    output logic [COLD_W-1:0]     cold_inflow,
    output logic [STATUS_W-1:0]   status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int QW    = FRAC_BITS + 7;
    localparam int UP_SH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DN_SH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    localparam logic signed [63:0] Q_MAX    = 64'sd1000000 <<< 26;
    localparam logic [63:0]        SAT_E    = 64'd1 << 60;
    localparam logic [63:0]        CAP_COEF = 64'd16736000;
    localparam logic [63:0]        MH_LIM   = SAT_E / CAP_COEF;
    localparam logic [QW-1:0]      NA_CAP   = QW'(10) << FRAC_BITS;
    localparam logic [QW-1:0]      NI_CAP   = QW'(100) << FRAC_BITS;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers
    logic signed [TEMP_W-1:0] target_temp_reg;
    logic [GAIN_W-1:0]        prop_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_temp_reg <= 17'sd5120;
            prop_gain_reg   <= 16'd1024;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TARGET: target_temp_reg <= cfg_data[TEMP_W-1:0];
                CFG_GAIN:   prop_gain_reg   <= cfg_data[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // stage 1: proportional demand
    logic                     v1_reg;
    logic signed [34:0]       d1_reg;
    logic signed [TEMP_W-1:0] t1_reg, ti1_reg, ta1_reg;
    logic [HEIGHT_W-1:0]      h1_reg;
    logic signed [17:0]       err1;
    logic signed [34:0]       d1_next;

    always_comb
    begin
        err1    = 18'(target_temp_reg) - 18'(signed'(water_temp));
        d1_next = 35'(signed'({1'b0, prop_gain_reg})) * 35'(err1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg  <= d1_next;
        t1_reg  <= water_temp;
        ti1_reg <= inlet_temp;
        ta1_reg <= ambient_temp;
        h1_reg  <= water_height;
    end

    // stage 2: demand times height, loss and hot water terms
    logic               v2_reg, dpos2_reg, dneg2_reg, mh_sat2_reg;
    logic [36:0]        mh2_reg;
    logic signed [45:0] loss2_reg;
    logic signed [52:0] hot2_reg;
    logic signed [17:0] da2_reg, di2_reg;
    logic [33:0]        md2;
    logic [47:0]        mh2;
    logic signed [17:0] dta2, da2_next, di2_next;

    always_comb
    begin
        md2      = d1_reg[34] ? 34'(-d1_reg) : d1_reg[33:0];
        mh2      = 48'(md2) * 48'(h1_reg);
        dta2     = 18'(t1_reg) - 18'(ta1_reg);
        da2_next = 18'sd20480 - 18'(t1_reg);
        di2_next = 18'(ti1_reg) - 18'(t1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dpos2_reg   <= !d1_reg[34] && (d1_reg != '0);
        dneg2_reg   <= d1_reg[34];
        mh_sat2_reg <= 64'(mh2) > MH_LIM;
        mh2_reg     <= mh2[36:0];
        loss2_reg   <= (46'(dta2) * 46'sd1000) <<< 18;
        hot2_reg    <= (53'(da2_next) * 53'sd41840) <<< 18;
        da2_reg     <= da2_next;
        di2_reg     <= di2_next;
    end

    // stage 3: energy rate and scaled divisors
    logic               v3_reg, dpos3_reg, dneg3_reg;
    logic signed [62:0] energy3_reg;
    logic signed [45:0] loss3_reg;
    logic signed [52:0] hot3_reg;
    logic signed [17:0] da3_reg, di3_reg;
    logic [DEN_W-1:0]   den_a3_reg, den_c3_reg;
    logic [60:0]        pm3;
    logic [17:0]        da_mag3, di_mag3;

    always_comb
    begin
        pm3     = mh_sat2_reg ? SAT_E[60:0] : 61'(mh2_reg) * CAP_COEF[60:0];
        da_mag3 = da2_reg[17] ? 18'(-da2_reg) : 18'(da2_reg);
        di_mag3 = di2_reg[17] ? 18'(-di2_reg) : 18'(di2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dpos3_reg   <= dpos2_reg;
        dneg3_reg   <= dneg2_reg;
        energy3_reg <= dneg2_reg ? -signed'(63'(pm3)) : signed'(63'(pm3));
        loss3_reg   <= loss2_reg;
        hot3_reg    <= hot2_reg;
        da3_reg     <= da2_reg;
        di3_reg     <= di2_reg;
        den_a3_reg  <= 32'(da_mag3) * 32'd16736;
        den_c3_reg  <= 32'(di_mag3) * 32'd16736;
    end

    // stage 4: heater split and divider numerators
    logic               v4_reg;
    ctl_t               ctl4_reg;
    logic [NUM_W-1:0]   num_a4_reg, num_c4_reg;
    logic [DEN_W-1:0]   den_a4_reg, den_c4_reg;
    logic signed [63:0] q4, num_a4, num_c4;
    ctl_t               ctl4_next;

    always_comb
    begin
        q4     = 64'(energy3_reg) - 64'(loss3_reg);
        num_a4 = q4 - Q_MAX;
        num_c4 = dpos3_reg ? q4 - 64'(hot3_reg) - Q_MAX : q4;

        ctl4_next.dpos    = dpos3_reg;
        ctl4_next.dneg    = dneg3_reg;
        ctl4_next.qge     = q4 >= Q_MAX;
        ctl4_next.heat_lo = q4[63] ? '0 : q4[45:26];
        ctl4_next.da_zero = da3_reg == '0;
        ctl4_next.da_neg  = da3_reg[17];
        ctl4_next.di_zero = di3_reg == '0;
        ctl4_next.neg_c   = num_c4[63] ^ di3_reg[17];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl4_reg   <= ctl4_next;
        num_a4_reg <= num_a4[63] ? NUM_W'(-num_a4) : num_a4[NUM_W-1:0];
        num_c4_reg <= num_c4[63] ? NUM_W'(-num_c4) : num_c4[NUM_W-1:0];
        den_a4_reg <= den_a3_reg;
        den_c4_reg <= den_c3_reg;
    end

    // flow quotients
    logic          dv_valid;
    ctl_t          dv_ctl;
    logic [QW-1:0] quot_a, quot_c;

    bte_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_ctl    (ctl4_reg),
        .num_a     (num_a4_reg),
        .den_a     (den_a4_reg),
        .num_c     (num_c4_reg),
        .den_c     (den_c4_reg),
        .out_valid (dv_valid),
        .out_ctl   (dv_ctl),
        .quot_a    (quot_a),
        .quot_c    (quot_c)
    );

    // final clamps and actuator selection
    logic [HEAT_W-1:0]   heat_next;
    logic [QW-1:0]       na_val, ni_val, cold_val;
    status_t             st_next;
    logic                na_negnz, na_sat;
    logic [QW+DN_SH-1:0] na_scaled, ni_scaled;

    always_comb
    begin
        na_negnz = dv_ctl.da_neg && (quot_a != '0);
        na_sat   = !dv_ctl.da_neg && (quot_a >= NA_CAP);
        cold_val = dv_ctl.neg_c ? '0 : ((quot_c >= NI_CAP) ? NI_CAP : quot_c);

        heat_next = '0;
        na_val    = '0;
        ni_val    = '0;
        st_next   = ST_OK;

        if (dv_ctl.dpos)
        begin
            heat_next = dv_ctl.heat_lo;
            if (dv_ctl.qge)
            begin
                heat_next = HEAT_W'(1000000);
                if (dv_ctl.da_zero)
                begin
                    st_next = ST_DIV_ZERO;
                end
                else if (na_negnz)
                begin
                    st_next = ST_HOT_NEG;
                end
                else if (na_sat)
                begin
                    na_val = NA_CAP;
                    if (dv_ctl.di_zero)
                    begin
                        st_next = ST_DIV_ZERO;
                    end
                    else
                    begin
                        ni_val = cold_val;
                    end
                end
                else
                begin
                    na_val = quot_a;
                end
            end
        end
        else if (dv_ctl.dneg)
        begin
            if (dv_ctl.di_zero)
            begin
                st_next = ST_DIV_ZERO;
            end
            else
            begin
                ni_val = cold_val;
            end
        end

        // convert from FRAC_BITS fraction bits to 1/65536 units
        na_scaled = ((QW+DN_SH)'(na_val) >> UP_SH) << DN_SH;
        ni_scaled = ((QW+DN_SH)'(ni_val) >> UP_SH) << DN_SH;
    end

    // output register
    logic                done_reg;
    logic [HEAT_W-1:0]   heater_power_reg;
    logic [HOT_W-1:0]    hot_inflow_reg;
    logic [COLD_W-1:0]   cold_inflow_reg;
    logic [STATUS_W-1:0] status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        heater_power_reg <= heat_next;
        hot_inflow_reg   <= HOT_W'(na_scaled);
        cold_inflow_reg  <= COLD_W'(ni_scaled);
        status_reg       <= st_next;
    end

    assign done         = done_reg;
    assign heater_power = heater_power_reg;
    assign hot_inflow   = hot_inflow_reg;
    assign cold_inflow  = cold_inflow_reg;
    assign status       = status_reg;

endmodule

[hdl/bte_div.sv]
module bte_div
    import bte_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  ctl_t                       in_ctl,
    input  logic [NUM_W-1:0]           num_a,
    input  logic [DEN_W-1:0]           den_a,
    input  logic [NUM_W-1:0]           num_c,
    input  logic [DEN_W-1:0]           den_c,
    output logic                       out_valid,
    output ctl_t                       out_ctl,
    output logic [FRAC_BITS+6:0]       quot_a,
    output logic [FRAC_BITS+6:0]       quot_c
);

    localparam int QW    = FRAC_BITS + 7;
    localparam int UP_SH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DN_SH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int MW    = NUM_W + UP_SH;
    localparam int RW    = DEN_W + QW;

    // stage arrays, index 0 is the entry register
    logic          valid_reg [0:QW];
    ctl_t          ctl_reg   [0:QW];
    logic [RW-1:0] rem_reg   [0:QW][2];
    logic [QW-1:0] quot_reg  [0:QW][2];
    logic [DEN_W-1:0] den_reg [0:QW][2];
    logic          sat_reg   [0:QW][2];

    logic [NUM_W-1:0] num_in [2];
    logic [DEN_W-1:0] den_in [2];

    assign num_in[0] = num_a;
    assign num_in[1] = num_c;
    assign den_in[0] = den_a;
    assign den_in[1] = den_c;

    // valid and side info shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg[0] <= in_ctl;
    end

    genvar j, l;
    generate
        // entry: scale numerator, detect quotient overflow
        for (l = 0; l < 2; l++)
        begin : g_entry
            logic [MW-1:0] m_val;
            logic          sat_next;

            always_comb
            begin
                m_val    = (MW'(num_in[l]) << UP_SH) >> DN_SH;
                sat_next = (m_val >> QW) >= MW'(den_in[l]);
            end

            always_ff @(posedge clk)
            begin
                rem_reg[0][l]  <= m_val[RW-1:0];
                quot_reg[0][l] <= '0;
                den_reg[0][l]  <= den_in[l];
                sat_reg[0][l]  <= sat_next;
            end
        end

        // one restoring step per stage, msb first
        for (j = 0; j < QW; j++)
        begin : g_stage
            localparam int B = QW - 1 - j;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[j+1] <= 1'b0;
                end
                else
                begin
                    valid_reg[j+1] <= valid_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                ctl_reg[j+1] <= ctl_reg[j];
            end

            for (l = 0; l < 2; l++)
            begin : g_lane
                logic [RW-1:0] dsh;
                logic          ge;
                logic [RW-1:0] rem_next;
                logic [QW-1:0] quot_next;

                always_comb
                begin
                    dsh       = RW'(den_reg[j][l]) << B;
                    ge        = rem_reg[j][l] >= dsh;
                    rem_next  = ge ? rem_reg[j][l] - dsh : rem_reg[j][l];
                    quot_next = quot_reg[j][l] | (QW'(ge) << B);
                end

                always_ff @(posedge clk)
                begin
                    rem_reg[j+1][l]  <= rem_next;
                    quot_reg[j+1][l] <= quot_next;
                    den_reg[j+1][l]  <= den_reg[j][l];
                    sat_reg[j+1][l]  <= sat_reg[j][l];
                end
            end
        end
    endgenerate

    // saturated quotient leaves as all ones
    assign out_valid = valid_reg[QW];
    assign out_ctl   = ctl_reg[QW];
    assign quot_a    = sat_reg[QW][0] ? '1 : quot_reg[QW][0];
    assign quot_c    = sat_reg[QW][1] ? '1 : quot_reg[QW][1];

endmodule
